/* sv/assert_macros.svh */
// assertion macros shared by the header detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge, held off while rst is high
`define AST_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in %m");

// checked at every clock edge, reset included
`define AST_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed in %m");

`endif

/* sv/macb_pkg.sv */
// types, constants and crc function for the header detector
package macb_pkg;

  localparam logic [7:0]  HDR_LEN      = 8'd128;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  VER_II       = 8'h81;
  localparam logic [7:0]  VER_III      = 8'h82;
  localparam logic [7:0]  NAME_MAX_LEN = 8'd63;
  localparam logic [7:0]  POS_NAME_LEN = 8'd1;
  localparam logic [7:0]  POS_ZERO_A   = 8'd74;
  localparam logic [7:0]  POS_ZERO_B   = 8'd82;
  localparam logic [7:0]  POS_WRITER   = 8'd122;
  localparam logic [7:0]  POS_READER   = 8'd123;
  localparam logic [7:0]  POS_CRC_HI   = 8'd124;
  localparam logic [7:0]  POS_CRC_LO   = 8'd125;
  localparam logic [31:0] MIN_FILE     = 32'd128;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic        last_byte;
    logic [31:0] total_size;
  } item_t;

  // crc-16 xmodem, one byte msb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/macb_in_reg.sv */
// input register stage of the header detector
module macb_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  macb_pkg::item_t in_item,
  input  logic           advance,
  output logic           in_stall,
  output logic           s1_valid,
  output macb_pkg::item_t s1_item
);

  logic load;
  logic s1_valid_next;

  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item <= in_item;
    end
  end

endmodule

/* sv/macb_hdr_check.sv */
// header field checks, crc tracking and byte position
`include "assert_macros.svh"

module macb_hdr_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  macb_pkg::item_t item,
  output logic            ok
);

  logic [7:0]  pos;
  logic [15:0] crc;
  logic        fields_valid;
  logic [7:0]  crc_high;

  logic [7:0]  pos_next;
  logic [15:0] crc_next;
  logic        fields_valid_next;
  logic [7:0]  crc_high_next;
  logic        in_hdr;
  logic        bad;
  logic [7:0]  b;
  logic        state_clear;

  assign b      = item.header_byte;
  assign in_hdr = !pos[7];

  always_comb begin
    bad = 1'b0;
    if (pos == 8'd0 && b != 8'd0) begin
      bad = 1'b1;
    end
    if (pos == macb_pkg::POS_NAME_LEN && (b == 8'd0 || b > macb_pkg::NAME_MAX_LEN)) begin
      bad = 1'b1;
    end
    if ((pos == macb_pkg::POS_ZERO_A || pos == macb_pkg::POS_ZERO_B) && b != 8'd0) begin
      bad = 1'b1;
    end
    if (pos == macb_pkg::POS_WRITER && b != macb_pkg::VER_II && b != macb_pkg::VER_III) begin
      bad = 1'b1;
    end
    if (pos == macb_pkg::POS_READER && b != macb_pkg::VER_II) begin
      bad = 1'b1;
    end
    if (pos == macb_pkg::POS_CRC_LO && crc != {crc_high, b}) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    pos_next          = pos;
    crc_next          = crc;
    fields_valid_next = fields_valid;
    crc_high_next     = crc_high;
    if (in_hdr) begin
      pos_next = pos + 8'd1;
      if (pos < macb_pkg::POS_CRC_HI) begin
        crc_next = macb_pkg::crc_update(crc, b);
      end
      if (pos == macb_pkg::POS_CRC_HI) begin
        crc_high_next = b;
      end
      if (bad) begin
        fields_valid_next = 1'b0;
      end
    end
  end

  assign ok = fields_valid_next && pos_next[7] && (item.total_size > macb_pkg::MIN_FILE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 8'd0;
      crc          <= 16'd0;
      fields_valid <= 1'b1;
      crc_high     <= 8'd0;
    end else if (advance) begin
      if (item.last_byte) begin
        pos          <= 8'd0;
        crc          <= 16'd0;
        fields_valid <= 1'b1;
        crc_high     <= 8'd0;
      end else begin
        pos          <= pos_next;
        crc          <= crc_next;
        fields_valid <= fields_valid_next;
        crc_high     <= crc_high_next;
      end
    end
  end

  assign state_clear = (pos == 8'd0) && fields_valid && (crc == 16'd0);

  // position saturates at the header length
  `AST_ALL(a_pos_sat, pos[7] |-> (pos[6:0] == 7'd0))
  // a last byte leaves the state at its reset values
  `AST_RST(a_clear_on_last, (advance && item.last_byte) |=> state_clear)

endmodule

/* sv/macbinary_header_detect.sv */
// top level of the macbinary ii/iii header detector
// Header bytes are taken one per cycle, back to back, through an input register;
// the field checks and the byte-wide crc-16 update sit between that register
// and the result register. A result is written to the result register when the
// byte marked last_byte leaves the input register, and waits there until taken;
// the input stalls only when a last byte is in the input register while an
// earlier result is still held.
// payload_offset is 128 when a complete, consistent header was seen and the
// file is larger than 128 bytes, otherwise 0. State clears after every result.
`include "assert_macros.svh"

module macbinary_header_detect (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  header_byte,
  input  logic        last_byte,
  input  logic [31:0] total_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        detected,
  output logic [7:0]  payload_offset
);

  macb_pkg::item_t in_item;
  macb_pkg::item_t s1_item;
  logic            s1_valid;
  logic            advance;
  logic            ok;
  logic            out_free;
  logic            out_valid_next;
  logic            offset_ok;

  assign in_item.header_byte = header_byte;
  assign in_item.last_byte   = last_byte;
  assign in_item.total_size  = total_size;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && (!s1_item.last_byte || out_free);

  macb_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  macb_hdr_check u_hdr_check (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .ok      (ok)
  );

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (advance && s1_item.last_byte) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.last_byte) begin
      detected       <= ok;
      payload_offset <= ok ? macb_pkg::HDR_LEN : 8'd0;
    end
  end

  assign offset_ok = detected ? (payload_offset == macb_pkg::HDR_LEN) : (payload_offset == 8'd0);

  // input backpressure only comes from a held result
  `AST_RST(a_stall_cause, in_stall |-> (s1_valid && s1_item.last_byte && out_valid && out_stall))
  // offset always agrees with the detect flag
  `AST_RST(a_offset_match, out_valid |-> offset_ok)

endmodule
